// ----- hw/rtl/sef_pkg.sv -----
// Shared types and constants for the silhouette edge finder.
`timescale 1ns / 1ps
package sef_pkg;

    localparam int IDX_BITS   = 10;
    localparam int POS_BITS   = 16;
    localparam int LIGHT_BITS = 16;
    localparam int TOTAL_BITS = 9;
    localparam int CFG_BITS   = 2;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_FACE  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [CFG_BITS-1:0] {
        CFG_LIGHT_X = 2'd0,
        CFG_LIGHT_Y = 2'd1,
        CFG_LIGHT_Z = 2'd2
    } t_cfg_index;

    typedef enum logic [3:0] {
        B_IDLE,
        B_V0,
        B_V1,
        B_V2,
        B_MUL,
        B_EDGE_START,
        B_SCAN,
        B_MOVE,
        B_APPEND,
        B_DONE
    } t_bstate;

    // A classified item as it waits in the queue between front and back.
    typedef struct packed {
        t_kind               kind;
        logic [2:0]          ok;
        logic [IDX_BITS-1:0] idx0;
        logic [IDX_BITS-1:0] idx1;
        logic [IDX_BITS-1:0] idx2;
        logic [POS_BITS-1:0] px;
        logic [POS_BITS-1:0] py;
        logic [POS_BITS-1:0] pz;
    } t_cmd;

endpackage

// ----- hw/rtl/sef_in_if.sv -----
// Input item channel of the silhouette edge finder.
`timescale 1ns / 1ps
interface sef_in_if;
    import sef_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [1:0]            kind;
    logic [IDX_BITS-1:0]   first_index;
    logic [IDX_BITS-1:0]   second_index;
    logic [IDX_BITS-1:0]   third_index;
    logic signed [POS_BITS-1:0] pos_x;
    logic signed [POS_BITS-1:0] pos_y;
    logic signed [POS_BITS-1:0] pos_z;

    modport source (output valid, kind, first_index, second_index, third_index,
                    pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, kind, first_index, second_index, third_index,
                  pos_x, pos_y, pos_z, output ready);
endinterface

// ----- hw/rtl/sef_out_if.sv -----
// Result channel of the silhouette edge finder.
`timescale 1ns / 1ps
interface sef_out_if;
    import sef_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [TOTAL_BITS-1:0] edge_total;
    logic                  lit_face;
    logic [IDX_BITS-1:0]   entry_start;
    logic [IDX_BITS-1:0]   entry_end;
    logic [1:0]            status;

    modport source (output valid, edge_total, lit_face, entry_start, entry_end, status,
                    input ready);
    modport sink (input valid, edge_total, lit_face, entry_start, entry_end, status,
                  output ready);
endinterface

// ----- hw/rtl/sef_front.sv -----
// Front end: accepts items, classifies them and holds them in a two-entry queue.
`timescale 1ns / 1ps
module sef_front
    import sef_pkg::*;
#(
    parameter int VERTEX_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sef_in_if.sink      i_item,
    output logic        o_q_valid,
    input  logic        i_q_pop,
    output t_cmd        o_q_cmd
);

    t_cmd       r_slot [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_fill;
    t_cmd       dec;
    logic       push;
    logic       pop;

    always_comb begin
        dec.kind = t_kind'(i_item.kind);
        dec.ok[0] = 32'(i_item.first_index) < 32'(VERTEX_DEPTH);
        dec.ok[1] = 32'(i_item.second_index) < 32'(VERTEX_DEPTH);
        dec.ok[2] = 32'(i_item.third_index) < 32'(VERTEX_DEPTH);
        dec.idx0 = i_item.first_index;
        dec.idx1 = i_item.second_index;
        dec.idx2 = i_item.third_index;
        dec.px = i_item.pos_x;
        dec.py = i_item.pos_y;
        dec.pz = i_item.pos_z;
    end

    assign i_item.ready = (r_fill != 2'd2);
    assign push = i_item.valid && i_item.ready;
    assign pop = i_q_pop && o_q_valid;
    assign o_q_valid = (r_fill != 2'd0);
    assign o_q_cmd = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= 1'b0;
            r_rd <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= dec;
        end
    end

endmodule

// ----- hw/rtl/sef_back.sv -----
// Back end: vertex store, facing test and edge table toggling, with the result register.
`timescale 1ns / 1ps
module sef_back
    import sef_pkg::*;
#(
    parameter int VERTEX_DEPTH  = 1024,
    parameter int EDGE_CAPACITY = 256,
    parameter int COORD_BITS    = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_BITS-1:0]   i_cfg_index,
    input  logic [LIGHT_BITS-1:0] i_cfg_data,
    input  logic                  i_q_valid,
    output logic                  o_q_pop,
    input  t_cmd                  i_q_cmd,
    sef_out_if.source             o_result
);

    localparam int CB = COORD_BITS;
    localparam int DW = CB + 1;
    localparam int PW = 2 * DW;
    localparam int NW = PW + 1;
    localparam int MW = NW + LIGHT_BITS;
    localparam int AW = MW + 2;
    localparam int VW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam int EW = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1;
    localparam int CW = $clog2(EDGE_CAPACITY + 1);
    localparam logic [3:0] STEP_LAST = 4'd9;

    t_bstate r_state;
    t_bstate n_state;

    // Memories
    logic [3*CB-1:0]       vmem [VERTEX_DEPTH];
    logic [3*CB-1:0]       r_vdata;
    logic                  v_we;
    logic                  v_re;
    logic [VW-1:0]         v_waddr;
    logic [VW-1:0]         v_raddr;
    logic [2*IDX_BITS-1:0] emem [EDGE_CAPACITY];
    logic [2*IDX_BITS-1:0] r_edata;
    logic                  e_we;
    logic                  e_re;
    logic [EW-1:0]         e_waddr;
    logic [EW-1:0]         e_raddr;
    logic [2*IDX_BITS-1:0] e_wdata;

    // Control and datapath registers
    logic signed [LIGHT_BITS-1:0] r_light [3];
    logic [CW-1:0]         r_count;
    t_cmd                  r_cmd;
    logic                  r_lit;
    logic                  r_drop;
    logic                  r_rd_ok;
    logic [3:0]            r_step;
    logic [1:0]            r_edge;
    logic [EW-1:0]         r_scan;
    logic signed [CB-1:0]  r_p0 [3];
    logic signed [CB-1:0]  r_p1 [3];
    logic signed [DW-1:0]  r_u [3];
    logic signed [DW-1:0]  r_w [3];
    logic signed [PW-1:0]  r_t;
    logic signed [NW-1:0]  r_n [3];
    logic signed [AW-1:0]  r_acc;
    logic                  r_out_valid;

    logic signed [CB-1:0]  pt [3];
    logic                  cur_ok;
    logic signed [DW-1:0]  mul_a;
    logic signed [DW-1:0]  mul_b;
    logic signed [PW-1:0]  prod;
    logic signed [NW-1:0]  dot_a;
    logic signed [LIGHT_BITS-1:0] dot_b;
    logic signed [MW-1:0]  dprod;
    logic [IDX_BITS-1:0]   cur_s;
    logic [IDX_BITS-1:0]   cur_e;
    logic [IDX_BITS-1:0]   ent_a;
    logic [IDX_BITS-1:0]   ent_b;
    logic                  match;
    logic                  full;
    logic                  more;
    logic                  rd_ok_now;
    logic                  out_free;
    logic                  out_load;
    logic                  is_read;

    // Corner coordinates as they come out of the vertex store.
    always_comb begin
        unique case (r_state)
            B_V0:    cur_ok = r_cmd.ok[0];
            B_V1:    cur_ok = r_cmd.ok[1];
            B_V2:    cur_ok = r_cmd.ok[2];
            default: cur_ok = 1'b0;
        endcase
        for (int k = 0; k < 3; k++) begin
            pt[k] = cur_ok ? r_vdata[k*CB +: CB] : '0;
        end
    end

    // Cross product terms in steps 0 to 5, dot product terms in steps 6 to 8.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        dot_a = '0;
        dot_b = '0;
        unique case (r_step)
            4'd0: begin mul_a = r_u[1]; mul_b = r_w[2]; end
            4'd1: begin mul_a = r_u[2]; mul_b = r_w[1]; end
            4'd2: begin mul_a = r_u[2]; mul_b = r_w[0]; end
            4'd3: begin mul_a = r_u[0]; mul_b = r_w[2]; end
            4'd4: begin mul_a = r_u[0]; mul_b = r_w[1]; end
            4'd5: begin mul_a = r_u[1]; mul_b = r_w[0]; end
            4'd6: begin dot_a = r_n[0]; dot_b = r_light[0]; end
            4'd7: begin dot_a = r_n[1]; dot_b = r_light[1]; end
            4'd8: begin dot_a = r_n[2]; dot_b = r_light[2]; end
            default: begin end
        endcase
    end

    assign prod = mul_a * mul_b;
    assign dprod = dot_a * dot_b;

    always_comb begin
        unique case (r_edge)
            2'd0:    begin cur_s = r_cmd.idx0; cur_e = r_cmd.idx1; end
            2'd1:    begin cur_s = r_cmd.idx1; cur_e = r_cmd.idx2; end
            default: begin cur_s = r_cmd.idx2; cur_e = r_cmd.idx0; end
        endcase
    end

    assign ent_a = r_edata[2*IDX_BITS-1:IDX_BITS];
    assign ent_b = r_edata[IDX_BITS-1:0];
    assign match = (ent_a == cur_s && ent_b == cur_e) || (ent_a == cur_e && ent_b == cur_s);
    assign full = (r_count >= CW'(EDGE_CAPACITY));
    assign more = ((CW'(r_scan) + CW'(1)) < r_count);
    assign rd_ok_now = 32'(i_q_cmd.idx0) < 32'(r_count);
    assign out_free = !r_out_valid || o_result.ready;
    assign is_read = (r_cmd.kind == KIND_READ);

    // Sequencer: next state and memory controls.
    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        v_we = 1'b0;
        v_waddr = VW'(i_q_cmd.idx0);
        v_re = 1'b0;
        v_raddr = VW'(i_q_cmd.idx0);
        e_we = 1'b0;
        e_waddr = r_scan;
        e_wdata = r_edata;
        e_re = 1'b0;
        e_raddr = '0;
        out_load = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_cmd.kind)
                        KIND_LOAD: begin
                            v_we = i_q_cmd.ok[0];
                            n_state = B_DONE;
                        end
                        KIND_FACE: begin
                            v_re = 1'b1;
                            n_state = B_V0;
                        end
                        KIND_READ: begin
                            e_re = rd_ok_now;
                            e_raddr = EW'(i_q_cmd.idx0);
                            n_state = B_DONE;
                        end
                        KIND_CLEAR: begin
                            n_state = B_DONE;
                        end
                    endcase
                end
            end
            B_V0: begin
                v_re = 1'b1;
                v_raddr = VW'(r_cmd.idx1);
                n_state = B_V1;
            end
            B_V1: begin
                v_re = 1'b1;
                v_raddr = VW'(r_cmd.idx2);
                n_state = B_V2;
            end
            B_V2: begin
                n_state = B_MUL;
            end
            B_MUL: begin
                if (r_step == STEP_LAST) begin
                    n_state = r_acc[AW-1] ? B_DONE : B_EDGE_START;
                end
            end
            B_EDGE_START: begin
                if (r_count == '0) begin
                    n_state = B_APPEND;
                end else begin
                    e_re = 1'b1;
                    e_raddr = '0;
                    n_state = B_SCAN;
                end
            end
            B_SCAN: begin
                if (match) begin
                    // The last entry moves into the matching slot.
                    e_re = 1'b1;
                    e_raddr = EW'(r_count - CW'(1));
                    n_state = B_MOVE;
                end else if (more) begin
                    e_re = 1'b1;
                    e_raddr = r_scan + EW'(1);
                end else begin
                    n_state = B_APPEND;
                end
            end
            B_MOVE: begin
                e_we = 1'b1;
                e_waddr = r_scan;
                e_wdata = r_edata;
                n_state = (r_edge == 2'd2) ? B_DONE : B_EDGE_START;
            end
            B_APPEND: begin
                e_we = !full;
                e_waddr = EW'(r_count);
                e_wdata = {cur_s, cur_e};
                n_state = (r_edge == 2'd2) ? B_DONE : B_EDGE_START;
            end
            B_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            vmem[v_waddr] <= {CB'(i_q_cmd.pz), CB'(i_q_cmd.py), CB'(i_q_cmd.px)};
        end
        if (v_re) begin
            r_vdata <= vmem[v_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_we) begin
            emem[e_waddr] <= e_wdata;
        end
        if (e_re) begin
            r_edata <= emem[e_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_count <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_light[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_LIGHT_X: r_light[0] <= i_cfg_data;
                    CFG_LIGHT_Y: r_light[1] <= i_cfg_data;
                    CFG_LIGHT_Z: r_light[2] <= i_cfg_data;
                    default: begin end
                endcase
            end
            if (r_state == B_IDLE && i_q_valid && i_q_cmd.kind == KIND_CLEAR) begin
                r_count <= '0;
            end else if (r_state == B_MOVE) begin
                r_count <= r_count - CW'(1);
            end else if (r_state == B_APPEND && !full) begin
                r_count <= r_count + CW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    r_cmd <= i_q_cmd;
                    r_lit <= 1'b0;
                    r_drop <= 1'b0;
                    r_rd_ok <= rd_ok_now;
                    r_step <= '0;
                    r_edge <= '0;
                end
            end
            B_V0: r_p0 <= pt;
            B_V1: r_p1 <= pt;
            B_V2: begin
                for (int k = 0; k < 3; k++) begin
                    r_u[k] <= DW'(r_p0[k]) - DW'(r_p1[k]);
                    r_w[k] <= DW'(pt[k]) - DW'(r_p1[k]);
                end
            end
            B_MUL: begin
                r_step <= r_step + 4'd1;
                unique case (r_step)
                    4'd0, 4'd2, 4'd4: r_t <= prod;
                    4'd1: r_n[0] <= NW'(r_t) - NW'(prod);
                    4'd3: r_n[1] <= NW'(r_t) - NW'(prod);
                    4'd5: r_n[2] <= NW'(r_t) - NW'(prod);
                    4'd6: r_acc <= AW'(dprod);
                    4'd7, 4'd8: r_acc <= r_acc + AW'(dprod);
                    default: r_lit <= !r_acc[AW-1];
                endcase
            end
            B_EDGE_START: r_scan <= '0;
            B_SCAN: begin
                if (!match) begin
                    r_scan <= r_scan + EW'(1);
                end
            end
            B_MOVE: r_edge <= r_edge + 2'd1;
            B_APPEND: begin
                r_edge <= r_edge + 2'd1;
                if (full) begin
                    r_drop <= 1'b1;
                end
            end
            default: begin end
        endcase
        if (out_load) begin
            o_result.edge_total <= TOTAL_BITS'(r_count);
            o_result.lit_face <= r_lit;
            o_result.entry_start <= (is_read && r_rd_ok) ? ent_a : '0;
            o_result.entry_end <= (is_read && r_rd_ok) ? ent_b : '0;
            if (is_read) begin
                o_result.status <= r_rd_ok ? ST_OK : ST_EMPTY;
            end else begin
                o_result.status <= r_drop ? ST_FULL : ST_OK;
            end
        end
    end

    assign o_result.valid = r_out_valid;

endmodule

// ----- hw/rtl/silhouette_edge_finder_core.sv -----
// Silhouette edge finder top level: front queue, back end and configuration port.
// Load, read and clear go from IDLE to DONE and then into the result register; a face
// takes three vertex store reads and ten multiply-state steps; a lit face adds, per edge,
// an EDGE_START step, a scan of the table through its read port, and a MOVE or APPEND.
// The back end takes a new item only from IDLE; the two-entry queue accepts items meanwhile.
// Reset clears the queue, edge count, light position and result valid; memories keep contents.
`timescale 1ns / 1ps
module silhouette_edge_finder_core
    import sef_pkg::*;
#(
    parameter int VERTEX_DEPTH  = 1024,
    parameter int EDGE_CAPACITY = 256,
    parameter int COORD_BITS    = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_BITS-1:0]   i_cfg_index,
    input  logic [LIGHT_BITS-1:0] i_cfg_data,
    sef_in_if.sink                i_item,
    sef_out_if.source             o_result
);

    logic q_valid;
    logic q_pop;
    t_cmd q_cmd;

    sef_front #(
        .VERTEX_DEPTH(VERTEX_DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .o_q_valid(q_valid),
        .i_q_pop  (q_pop),
        .o_q_cmd  (q_cmd)
    );

    sef_back #(
        .VERTEX_DEPTH (VERTEX_DEPTH),
        .EDGE_CAPACITY(EDGE_CAPACITY),
        .COORD_BITS   (COORD_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .o_q_pop    (q_pop),
        .i_q_cmd    (q_cmd),
        .o_result   (o_result)
    );

endmodule

// ----- verif/tb_silhouette_edge_finder_core.sv -----
// Self-checking testbench for the silhouette edge finder core.
`timescale 1ns / 1ps
module tb_silhouette_edge_finder_core;
    import sef_pkg::*;

    localparam int  EDGE_CAP    = 256;
    localparam int  VERT_DEPTH  = 1024;
    localparam int  POOL        = 64;
    localparam int  PHASE_ITEMS = 560;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct {
        t_kind                      kind;
        logic [IDX_BITS-1:0]        i0;
        logic [IDX_BITS-1:0]        i1;
        logic [IDX_BITS-1:0]        i2;
        logic signed [POS_BITS-1:0] px;
        logic signed [POS_BITS-1:0] py;
        logic signed [POS_BITS-1:0] pz;
    } t_item;

    typedef struct {
        logic [TOTAL_BITS-1:0] total;
        logic                  lit;
        logic [IDX_BITS-1:0]   es;
        logic [IDX_BITS-1:0]   ee;
        logic [1:0]            st;
    } t_outcome;

    class silhouette_scoreboard;
        longint              vx [VERT_DEPTH];
        longint              vy [VERT_DEPTH];
        longint              vz [VERT_DEPTH];
        logic [IDX_BITS-1:0] ea [EDGE_CAP];
        logic [IDX_BITS-1:0] eb [EDGE_CAP];
        int                  held;
        longint              lx, ly, lz;
        t_outcome            pending_q [$];
        int                  errors, lit_faces, drops, good_reads, accepted;

        function new();
            held = 0; lx = 0; ly = 0; lz = 0;
            errors = 0; lit_faces = 0; drops = 0; good_reads = 0; accepted = 0;
            for (int i = 0; i < VERT_DEPTH; i++) begin
                vx[i] = 0; vy[i] = 0; vz[i] = 0;
            end
        endfunction

        function void set_light(t_cfg_index idx, logic [LIGHT_BITS-1:0] val);
            case (idx)
                CFG_LIGHT_X: lx = longint'($signed(val));
                CFG_LIGHT_Y: ly = longint'($signed(val));
                CFG_LIGHT_Z: lz = longint'($signed(val));
                default: ;
            endcase
        endfunction

        // Returns 1 when the edge could not be appended because the table was full.
        function bit toggle(logic [IDX_BITS-1:0] s, logic [IDX_BITS-1:0] e);
            for (int i = 0; i < held; i++) begin
                if ((ea[i] == s && eb[i] == e) || (ea[i] == e && eb[i] == s)) begin
                    ea[i] = ea[held-1];
                    eb[i] = eb[held-1];
                    held--;
                    return 0;
                end
            end
            if (held >= EDGE_CAP) return 1;
            ea[held] = s;
            eb[held] = e;
            held++;
            return 0;
        endfunction

        function void note(t_item it);
            t_outcome o;
            longint   ux, uy, uz, wx, wy, wz, nx, ny, nz, d;
            bit       dropped;
            o = '{total: '0, lit: 1'b0, es: '0, ee: '0, st: ST_OK};
            accepted++;
            case (it.kind)
                KIND_LOAD: begin
                    vx[it.i0] = it.px; vy[it.i0] = it.py; vz[it.i0] = it.pz;
                end
                KIND_FACE: begin
                    ux = vx[it.i0] - vx[it.i1]; uy = vy[it.i0] - vy[it.i1];
                    uz = vz[it.i0] - vz[it.i1];
                    wx = vx[it.i2] - vx[it.i1]; wy = vy[it.i2] - vy[it.i1];
                    wz = vz[it.i2] - vz[it.i1];
                    nx = uy * wz - uz * wy;
                    ny = uz * wx - ux * wz;
                    nz = ux * wy - uy * wx;
                    d  = nx * lx + ny * ly + nz * lz;
                    if (d >= 0) begin
                        o.lit = 1'b1;
                        lit_faces++;
                        dropped = toggle(it.i0, it.i1);
                        dropped = toggle(it.i1, it.i2) | dropped;
                        dropped = toggle(it.i2, it.i0) | dropped;
                        if (dropped) begin
                            o.st = ST_FULL;
                            drops++;
                        end
                    end
                end
                KIND_READ: begin
                    if (it.i0 < held) begin
                        o.es = ea[it.i0];
                        o.ee = eb[it.i0];
                        good_reads++;
                    end else begin
                        o.st = ST_EMPTY;
                    end
                end
                default: held = 0;
            endcase
            o.total = TOTAL_BITS'(held);
            pending_q.push_back(o);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        task check(t_outcome got);
            t_outcome want;
            if (pending_q.size() == 0) begin
                report("unexpected transaction, edge_total", got.total, -1);
            end else begin
                want = pending_q.pop_front();
                if (got.total !== want.total) report("edge_total", got.total, want.total);
                if (got.lit !== want.lit) report("lit_face", got.lit, want.lit);
                if (got.es !== want.es) report("entry_start", got.es, want.es);
                if (got.ee !== want.ee) report("entry_end", got.ee, want.ee);
                if (got.st !== want.st) report("status", got.st, want.st);
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_BITS-1:0]   i_cfg_index;
    logic [LIGHT_BITS-1:0] i_cfg_data;

    sef_in_if  in_if ();
    sef_out_if out_if ();

    silhouette_edge_finder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (in_if),
        .o_result    (out_if)
    );

    silhouette_scoreboard sb = new();

    int     send_idle = 0;
    int     recv_idle = 0;
    longint cycles    = 0;
    bit     written [VERT_DEPTH];
    int     written_list [$];

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    always @(posedge i_clk) begin
        t_item    it;
        t_outcome r;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL silhouette_edge_finder_core");
            $finish;
        end
        if (i_rst_n && in_if.valid && in_if.ready) begin
            it.kind = t_kind'(in_if.kind);
            it.i0 = in_if.first_index; it.i1 = in_if.second_index;
            it.i2 = in_if.third_index;
            it.px = in_if.pos_x; it.py = in_if.pos_y; it.pz = in_if.pos_z;
            sb.note(it);
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            r.total = out_if.edge_total; r.lit = out_if.lit_face;
            r.es = out_if.entry_start; r.ee = out_if.entry_end; r.st = out_if.status;
            sb.check(r);
        end
    end

    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= recv_idle);
    end

    // Returns at the rising edge where the transaction was accepted; valid stays
    // high until the next falling edge decides on another item or a gap.
    task send_item(t_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.kind = it.kind;
        in_if.first_index = it.i0; in_if.second_index = it.i1; in_if.third_index = it.i2;
        in_if.pos_x = it.px; in_if.pos_y = it.py; in_if.pos_z = it.pz;
        in_if.valid = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        if (it.kind == KIND_LOAD && !written[it.i0]) begin
            written[it.i0] = 1'b1;
            written_list.push_back(it.i0);
        end
    endtask

    task drain();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task write_light(t_cfg_index idx, logic [LIGHT_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1; i_cfg_index = idx; i_cfg_data = val;
        sb.set_light(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task set_lights(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        drain();
        write_light(CFG_LIGHT_X, x);
        write_light(CFG_LIGHT_Y, y);
        write_light(CFG_LIGHT_Z, z);
    endtask

    function t_item mk(t_kind k, int a, int b, int c, int x, int y, int z);
        t_item it;
        it.kind = k; it.i0 = IDX_BITS'(a); it.i1 = IDX_BITS'(b); it.i2 = IDX_BITS'(c);
        it.px = POS_BITS'(x); it.py = POS_BITS'(y); it.pz = POS_BITS'(z);
        return it;
    endfunction

    function logic [15:0] rand_coord();
        case ($urandom_range(7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom_range(16) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    function int pick_corner();
        if ($urandom_range(9) != 0) return $urandom_range(POOL - 1);
        return written_list[$urandom_range(written_list.size() - 1)];
    endfunction

    function t_item rand_item();
        t_item it;
        int    roll;
        it = mk(KIND_FACE, pick_corner(), pick_corner(), pick_corner(),
                $urandom, $urandom, $urandom);
        roll = $urandom_range(99);
        if (roll < 18) begin
            it.kind = KIND_LOAD;
            it.i0 = ($urandom_range(9) == 0) ? IDX_BITS'($urandom_range(VERT_DEPTH - 1))
                                             : IDX_BITS'($urandom_range(POOL - 1));
            it.px = rand_coord(); it.py = rand_coord(); it.pz = rand_coord();
        end else if (roll < 78) begin
            // Now and then a face repeats a corner, so edges with equal ends occur.
            if ($urandom_range(19) == 0) it.i2 = it.i1;
        end else if (roll < 97) begin
            it.kind = KIND_READ;
            it.i0 = ($urandom_range(4) == 0) ? IDX_BITS'($urandom_range(VERT_DEPTH - 1))
                                             : IDX_BITS'($urandom_range(EDGE_CAP + 8));
        end else begin
            it.kind = KIND_CLEAR;
        end
        return it;
    endfunction

    task random_phase(int sidle, int ridle);
        send_idle = sidle;
        recv_idle = ridle;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(199) == 0) drain();
            send_item(rand_item());
        end
    endtask

    initial begin
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        in_if.valid = 1'b0; in_if.kind = '0;
        in_if.first_index = '0; in_if.second_index = '0; in_if.third_index = '0;
        in_if.pos_x = '0; in_if.pos_y = '0; in_if.pos_z = '0;
        out_if.ready = 1'b0;
        for (int i = 0; i < VERT_DEPTH; i++) written[i] = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, light at its reset value of zero: every face is lit.
        send_item(mk(KIND_LOAD, 0, 0, 0, 32767, 32767, 32767));
        send_item(mk(KIND_LOAD, 1, 1023, 1023, -32768, -32768, -32768));
        send_item(mk(KIND_LOAD, 2, 0, 0, 0, 0, 0));
        send_item(mk(KIND_LOAD, 3, 0, 0, 1, -1, 0));
        send_item(mk(KIND_LOAD, 1023, 0, 0, -32768, 32767, 7));
        send_item(mk(KIND_FACE, 0, 1, 2, 0, 0, 0));
        send_item(mk(KIND_READ, 0, 1023, 1023, 0, 0, 0));
        send_item(mk(KIND_READ, 2, 0, 0, 0, 0, 0));
        send_item(mk(KIND_READ, 3, 0, 0, 0, 0, 0));
        send_item(mk(KIND_READ, 1023, 0, 0, 0, 0, 0));
        send_item(mk(KIND_FACE, 0, 1, 2, 0, 0, 0));
        send_item(mk(KIND_FACE, 3, 3, 3, 0, 0, 0));
        send_item(mk(KIND_READ, 0, 0, 0, 0, 0, 0));
        send_item(mk(KIND_FACE, 2, 2, 1023, 0, 0, 0));
        send_item(mk(KIND_CLEAR, 1023, 1023, 1023, -1, -1, -1));
        send_item(mk(KIND_READ, 0, 0, 0, 0, 0, 0));

        // An index past the register list must leave the light untouched.
        set_lights(16'h7fff, 16'h8000, 16'h0001);
        @(negedge i_clk);
        i_cfg_we = 1'b1; i_cfg_index = 2'd3; i_cfg_data = 16'h8000;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        send_item(mk(KIND_FACE, 0, 3, 1023, 0, 0, 0));
        send_item(mk(KIND_FACE, 0, 1023, 3, 0, 0, 0));
        send_item(mk(KIND_FACE, 0, 1, 2, 0, 0, 0));
        send_item(mk(KIND_READ, 1, 0, 0, 0, 0, 0));

        drain();
        for (int v = 0; v < POOL; v++)
            send_item(mk(KIND_LOAD, v, $urandom, $urandom, rand_coord(), rand_coord(),
                         rand_coord()));

        set_lights(16'($urandom), 16'($urandom), 16'($urandom));
        random_phase(30, 69);
        set_lights(16'h8000, 16'h7fff, 16'h8000);
        random_phase(69, 30);
        // Zero light keeps every face lit, which drives the table into its full state.
        set_lights(16'h0000, 16'h0000, 16'h0000);
        random_phase(0, 0);

        drain();
        $display("covered %0d transactions: %0d lit faces, %0d with dropped edges, %0d reads",
                 sb.accepted, sb.lit_faces, sb.drops, sb.good_reads);
        $display("light settings: random, extremes and zero, under three idling patterns");
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("PASS silhouette_edge_finder_core");
        end else begin
            $display("FAIL silhouette_edge_finder_core");
        end
        $finish;
    end

endmodule
